// ===== rtl/fprc_pkg.sv =====
// shared types, constants and crc helper for the framed packet receiver
`timescale 1ns / 1ps

package fprc_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned CSR_IDX_W = 8;

   localparam logic [COUNT_W-1:0] CRC_INIT = 16'hFFFF;
   localparam logic [COUNT_W-1:0] CRC_POLY = 16'hA001;
   localparam logic [BYTE_W-1:0]  MIN_LENGTH = 8'd2;

   localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET  = 8'd10;
   localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hAA;
   localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'h55;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_SYNC  = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_SYNC = 8'd2;

   // item operation codes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [2:0] {
      PH_SYNC1  = 3'd0,
      PH_SYNC2  = 3'd1,
      PH_LENGTH = 3'd2,
      PH_DATA   = 3'd3,
      PH_CRCLO  = 3'd4,
      PH_CRCHI  = 3'd5
   } phase_type;

   typedef struct packed {
      logic                      frame_good;
      logic                      frame_error;
      logic signed [BYTE_W-1:0]  speed_cmd;
      logic signed [BYTE_W-1:0]  turn_cmd;
      logic [COUNT_W-1:0]        good_total;
      logic [COUNT_W-1:0]        error_total;
   } result_type;

   typedef struct packed {
      logic [BYTE_W-1:0] max_length;
      logic [BYTE_W-1:0] first_sync;
      logic [BYTE_W-1:0] second_sync;
   } csr_type;

   // crc-16/modbus update by one byte, lsb first
   function automatic logic [COUNT_W-1:0] crc_add_byte(input logic [COUNT_W-1:0] crc,
                                                      input logic [BYTE_W-1:0]  b);
      logic [COUNT_W-1:0] c;
      c = crc ^ {{(COUNT_W-BYTE_W){1'b0}}, b};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== rtl/fprc_parser.sv =====
// frame parser state, crc check, held commands and counters
`timescale 1ns / 1ps

module fprc_parser
   import fprc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic              operation,
   input  logic [BYTE_W-1:0] rx_byte,
   input  csr_type           csr,
   output result_type        result
);

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  exp_len_ff, exp_len_in;
   logic [BYTE_W-1:0]  seen_ff, seen_in;
   logic [COUNT_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0]  crc_lo_ff, crc_lo_in;
   logic [BYTE_W-1:0]  pay0_ff, pay0_in;
   logic [BYTE_W-1:0]  pay1_ff, pay1_in;
   logic [BYTE_W-1:0]  speed_ff, speed_in;
   logic [BYTE_W-1:0]  turn_ff, turn_in;
   logic [COUNT_W-1:0] good_cnt_ff, good_cnt_in;
   logic [COUNT_W-1:0] bad_cnt_ff, bad_cnt_in;

   logic               good, bad;
   logic [BYTE_W-1:0]  seen_inc;
   logic               crc_match;

   assign seen_inc  = seen_ff + 8'd1;
   assign crc_match = ({rx_byte, crc_lo_ff} == crc_ff);

   // next state
   always_comb begin
      phase_in   = phase_ff;
      exp_len_in = exp_len_ff;
      seen_in    = seen_ff;
      crc_in     = crc_ff;
      crc_lo_in  = crc_lo_ff;
      pay0_in    = pay0_ff;
      pay1_in    = pay1_ff;
      speed_in   = speed_ff;
      turn_in    = turn_ff;
      if (operation == OP_RESTART) begin
         phase_in   = PH_SYNC1;
         exp_len_in = '0;
         seen_in    = '0;
         crc_in     = CRC_INIT;
         speed_in   = '0;
         turn_in    = '0;
      end else begin
         case (phase_ff)
            PH_SYNC2: begin
               phase_in = (rx_byte == csr.second_sync) ? PH_LENGTH : PH_SYNC1;
            end
            PH_LENGTH: begin
               if (rx_byte >= MIN_LENGTH && rx_byte <= csr.max_length) begin
                  exp_len_in = rx_byte;
                  seen_in    = '0;
                  crc_in     = CRC_INIT;
                  phase_in   = PH_DATA;
               end else begin
                  phase_in = PH_SYNC1;
               end
            end
            PH_DATA: begin
               if (seen_ff == 8'd0) begin
                  pay0_in = rx_byte;
               end else if (seen_ff == 8'd1) begin
                  pay1_in = rx_byte;
               end
               crc_in  = crc_add_byte(crc_ff, rx_byte);
               seen_in = seen_inc;
               if (seen_inc >= exp_len_ff) begin
                  phase_in = PH_CRCLO;
               end
            end
            PH_CRCLO: begin
               crc_lo_in = rx_byte;
               phase_in  = PH_CRCHI;
            end
            PH_CRCHI: begin
               if (crc_match) begin
                  speed_in = pay0_ff;
                  turn_in  = pay1_ff;
               end
               phase_in   = PH_SYNC1;
               exp_len_in = '0;
               seen_in    = '0;
               crc_in     = CRC_INIT;
            end
            default: begin
               // unused codes hunt like the first sync phase
               phase_in = (rx_byte == csr.first_sync) ? PH_SYNC2 : PH_SYNC1;
            end
         endcase
      end
   end

   // outputs
   always_comb begin
      good = 1'b0;
      bad  = 1'b0;
      if (operation == OP_BYTE) begin
         case (phase_ff)
            PH_SYNC2:  bad = (rx_byte != csr.second_sync);
            PH_LENGTH: bad = !(rx_byte >= MIN_LENGTH && rx_byte <= csr.max_length);
            PH_CRCHI: begin
               good = crc_match;
               bad  = !crc_match;
            end
            default: begin
               good = 1'b0;
               bad  = 1'b0;
            end
         endcase
      end
      good_cnt_in = good_cnt_ff + {{(COUNT_W-1){1'b0}}, good};
      bad_cnt_in  = bad_cnt_ff + {{(COUNT_W-1){1'b0}}, bad};
      result.frame_good  = good;
      result.frame_error = bad;
      result.speed_cmd   = speed_in;
      result.turn_cmd    = turn_in;
      result.good_total  = good_cnt_in;
      result.error_total = bad_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SYNC1;
         exp_len_ff  <= '0;
         seen_ff     <= '0;
         crc_ff      <= CRC_INIT;
         crc_lo_ff   <= '0;
         pay0_ff     <= '0;
         pay1_ff     <= '0;
         speed_ff    <= '0;
         turn_ff     <= '0;
         good_cnt_ff <= '0;
         bad_cnt_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         exp_len_ff  <= exp_len_in;
         seen_ff     <= seen_in;
         crc_ff      <= crc_in;
         crc_lo_ff   <= crc_lo_in;
         pay0_ff     <= pay0_in;
         pay1_ff     <= pay1_in;
         speed_ff    <= speed_in;
         turn_ff     <= turn_in;
         good_cnt_ff <= good_cnt_in;
         bad_cnt_ff  <= bad_cnt_in;
      end
   end

   a_good_bad_excl: assert property (@(posedge clock) disable iff (reset)
      !(result.frame_good && result.frame_error))
      else $error("frame marked good and bad at once");

   a_good_count: assert property (@(posedge clock) disable iff (reset)
      step && result.frame_good |=> good_cnt_ff == $past(good_cnt_ff) + 16'd1)
      else $error("good counter missed a good frame");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      step && operation == OP_RESTART |=>
         phase_ff == PH_SYNC1 && speed_ff == '0 && turn_ff == '0
         && crc_ff == CRC_INIT)
      else $error("restart did not clear parser and commands");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(crc_ff) && $stable(bad_cnt_ff))
      else $error("parser state moved without an item");

endmodule

// ===== rtl/framed_packet_receiver_crc16.sv =====
// top level of the framed packet receiver with crc-16/modbus check
// an accepted item waits in the input register until the result register can take it
// throughput: one item per cycle while rsp_stall is low; the byte-wide crc update
// sits between the input and result registers, so a new byte may enter every cycle
// reset: synchronous, active high; parser hunts the first sync byte, counters and
// held commands are zero, configuration returns to max length 10, sync bytes aa/55
`timescale 1ns / 1ps

module framed_packet_receiver_crc16
   import fprc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   // input item channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_operation,
   input  logic [BYTE_W-1:0]        req_rx_byte,

   // result item channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_frame_good,
   output logic                     rsp_frame_error,
   output logic signed [BYTE_W-1:0] rsp_speed_cmd,
   output logic signed [BYTE_W-1:0] rsp_turn_cmd,
   output logic [COUNT_W-1:0]       rsp_good_total,
   output logic [COUNT_W-1:0]       rsp_error_total,

   // configuration write port
   input  logic                     csr_write_enable,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [BYTE_W-1:0]        csr_write_data
);

   // configuration registers
   csr_type     csr_ff, csr_in;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               op_ff;
   logic [BYTE_W-1:0]  byte_ff;

   // result register
   logic               out_valid_ff, out_valid_in;
   result_type         res_ff;
   result_type         res_next;

   logic               accept;
   logic               advance;

   // the input item moves on when the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MAX_LENGTH:  csr_in.max_length  = csr_write_data;
            CSR_FIRST_SYNC:  csr_in.first_sync  = csr_write_data;
            CSR_SECOND_SYNC: csr_in.second_sync = csr_write_data;
            default:         csr_in = csr_ff;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // parser works on the registered item and commits on advance
   fprc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .operation (op_ff),
      .rx_byte   (byte_ff),
      .csr       (csr_ff),
      .result    (res_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.max_length  <= MAX_LENGTH_RESET;
         csr_ff.first_sync  <= FIRST_SYNC_RESET;
         csr_ff.second_sync <= SECOND_SYNC_RESET;
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         csr_ff       <= csr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         byte_ff <= req_rx_byte;
      end
      if (advance) begin
         res_ff <= res_next;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_frame_good  = res_ff.frame_good;
   assign rsp_frame_error = res_ff.frame_error;
   assign rsp_speed_cmd   = res_ff.speed_cmd;
   assign rsp_turn_cmd    = res_ff.turn_cmd;
   assign rsp_good_total  = res_ff.good_total;
   assign rsp_error_total = res_ff.error_total;

endmodule
